@@ design/spwm_pkg.sv @@
// Shared types and constants for the servo pulse generator with serial commands.
// No dependencies; imported by servo_pwm_with_serial_commands_top.
package spwm_pkg;

    // Item kinds on the input channel
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    // Command characters
    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CHAR_P       = 8'h50;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // Visible servo lines and frame defaults
    localparam int          LINES_OUT_W   = 4;
    localparam logic [15:0] FRAME_DEFAULT = 16'd2000;

    // Pulse targets after reset for the first four channels
    typedef logic [7:0] pulse_t;
    localparam pulse_t TARGET_DEFAULT [4] = '{8'd122, 8'd148, 8'd209, 8'd101};

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CHAN   = 3'd1,
        PH_WANT_P = 3'd2,
        PH_DIGITS = 3'd3,
        PH_SKIP   = 3'd4
    } phase_t;

endpackage

@@ design/servo_pwm_with_serial_commands_top.sv @@
// Servo pulse generator with a byte-wide command parser, top level.
// Depends on spwm_pkg for command characters, phase codes and reset targets.
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per item: op = 0 is a
//   timer tick that advances the frame counter, op = 1 delivers rx_byte to the
//   command parser ("S<ch>P<digits>\n"). Every input beat produces exactly one
//   output beat on (out_valid / out_stall) with the line levels after the item
//   and target_updated set when the byte completed a target write.
//   The configuration channel (cfg_valid / cfg_ready) writes frame_length;
//   cfg_ready is always high and writes belong in idle periods.
// Timing:
//   An accepted beat sits in the input register; out_valid rises when it moves
//   on into the result register. Throughput is one item per cycle while
//   out_stall holds no result, as counter and parser update with each item.
// Reset:
//   Counter, shadows and lines clear, targets return to 122/148/209/101, the
//   parser waits for 'S' and frame_length returns to 2000.
// Backpressure:
//   While out_stall holds a result, the input register fills and then in_stall
//   rises; no beat is lost or repeated.
module servo_pwm_with_serial_commands_top
    import spwm_pkg::*;
#(
    parameter int CHANNELS      = 4,
    parameter int CMD_MAX_CHARS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  servo_lines,
    output logic        target_updated
);

    localparam logic [3:0] MAX_CHARS  = 4'(CMD_MAX_CHARS);
    localparam logic [7:0] CHAN_FIRST = 8'(49);
    localparam logic [7:0] CHAN_LAST  = 8'(48 + CHANNELS);

    // Input stage
    logic       in_vld_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    // Block state
    logic [15:0]         frame_len_reg;
    logic [15:0]         tick_reg,   tick_next;
    pulse_t              target_reg [CHANNELS];
    pulse_t              target_next[CHANNELS];
    pulse_t              shadow_reg [CHANNELS];
    pulse_t              shadow_next[CHANNELS];
    logic [CHANNELS-1:0] lines_reg,  lines_next;
    phase_t              phase_reg,  phase_next;
    logic [3:0]          index_reg,  index_next;
    logic [7:0]          chan_reg,   chan_next;
    logic [7:0]          acc_reg,    acc_next;
    logic                ended_reg,  ended_next;
    logic                upd_next;

    // Result stage
    logic       out_vld_reg;
    logic [3:0] lines_out_reg;
    logic       upd_out_reg;

    // Helpers
    logic                   advance;
    logic                   fire;
    logic [15:0]            tick_inc;
    logic                   wrap;
    logic [3:0]             index_inc;
    logic [7:0]             acc_step;
    logic                   chan_ok;
    logic [CHANNELS+3:0]    lines_ext;

    assign cfg_ready = 1'b1;

    // Move a beat into the result register when it is empty or being taken
    assign advance  = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;

    assign out_valid      = out_vld_reg;
    assign servo_lines    = lines_out_reg;
    assign target_updated = upd_out_reg;

    assign tick_inc  = tick_reg + 16'd1;
    assign wrap      = (tick_inc >= frame_len_reg);
    assign index_inc = index_reg + 4'd1;
    assign acc_step  = {acc_reg[4:0], 3'b000} + {acc_reg[6:0], 1'b0}
                       + in_byte_reg - CHAR_ZERO;
    assign chan_ok   = (chan_reg >= CHAN_FIRST) && (chan_reg <= CHAN_LAST);
    assign lines_ext = {4'b0000, lines_next};

    // Compute the state after the item held in the input register
    always_comb
    begin
        tick_next   = tick_reg;
        lines_next  = lines_reg;
        phase_next  = phase_reg;
        index_next  = index_reg;
        chan_next   = chan_reg;
        acc_next    = acc_reg;
        ended_next  = ended_reg;
        upd_next    = 1'b0;
        for (int n = 0; n < CHANNELS; n++)
        begin
            target_next[n] = target_reg[n];
            shadow_next[n] = shadow_reg[n];
        end

        if (in_op_reg == OP_TICK)
        begin
            // Advance the frame counter; wrap raises all lines
            if (wrap)
            begin
                tick_next  = '0;
                lines_next = '1;
                for (int n = 0; n < CHANNELS; n++)
                begin
                    shadow_next[n] = target_reg[n];
                end
            end
            else
            begin
                tick_next = tick_inc;
                for (int n = 0; n < CHANNELS; n++)
                begin
                    if (tick_inc == {8'd0, shadow_reg[n]})
                    begin
                        lines_next[n] = 1'b0;
                    end
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_CHAN, PH_WANT_P, PH_DIGITS:
                begin
                    if (in_byte_reg == CHAR_NEWLINE)
                    begin
                        // Newline ends the command and drops the next byte
                        if (phase_reg != PH_CHAN)
                        begin
                            upd_next = chan_ok;
                        end
                        phase_next = PH_SKIP;
                    end
                    else if (phase_reg == PH_WANT_P && in_byte_reg != CHAR_P)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        if (phase_reg == PH_CHAN)
                        begin
                            chan_next  = in_byte_reg;
                            phase_next = PH_WANT_P;
                        end
                        else if (phase_reg == PH_WANT_P)
                        begin
                            phase_next = PH_DIGITS;
                        end
                        else if (in_byte_reg == CHAR_NUL)
                        begin
                            ended_next = 1'b1;
                        end
                        else if (!ended_reg)
                        begin
                            acc_next = acc_step;
                        end
                        index_next = index_inc;
                        // Close the command at the length limit
                        if (index_inc >= MAX_CHARS)
                        begin
                            upd_next   = (phase_reg != PH_CHAN) ? chan_ok
                                         : ((in_byte_reg >= CHAN_FIRST)
                                            && (in_byte_reg <= CHAN_LAST));
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_SKIP:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    if (in_byte_reg == CHAR_S)
                    begin
                        phase_next = PH_CHAN;
                        index_next = '0;
                        chan_next  = '0;
                        acc_next   = '0;
                        ended_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase

            // Write the finished value to the addressed channel
            for (int n = 0; n < CHANNELS; n++)
            begin
                if (upd_next && (chan_next == 8'(49 + n)))
                begin
                    target_next[n] = acc_next;
                end
            end
        end
    end

    // Input register and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            frame_len_reg <= FRAME_DEFAULT;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                frame_len_reg <= cfg_data;
            end
            if (!in_stall)
            begin
                in_vld_reg <= in_valid;
            end
        end
    end

    // Hold input payload while stalled
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_op_reg   <= op;
            in_byte_reg <= rx_byte;
        end
    end

    // Block state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            lines_reg     <= '0;
            phase_reg     <= PH_IDLE;
            index_reg     <= '0;
            chan_reg      <= '0;
            acc_reg       <= '0;
            ended_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
            lines_out_reg <= '0;
            upd_out_reg   <= 1'b0;
            for (int n = 0; n < CHANNELS; n++)
            begin
                target_reg[n] <= (n < 4) ? TARGET_DEFAULT[n % 4] : 8'd0;
                shadow_reg[n] <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                tick_reg      <= tick_next;
                lines_reg     <= lines_next;
                phase_reg     <= phase_next;
                index_reg     <= index_next;
                chan_reg      <= chan_next;
                acc_reg       <= acc_next;
                ended_reg     <= ended_next;
                lines_out_reg <= lines_ext[LINES_OUT_W-1:0];
                upd_out_reg   <= upd_next;
                for (int n = 0; n < CHANNELS; n++)
                begin
                    target_reg[n] <= target_next[n];
                    shadow_reg[n] <= shadow_next[n];
                end
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

`ifndef SYNTHESIS
    // A tick never reports a target write
    a_tick_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_op_reg == OP_TICK |=> !upd_out_reg)
        else $error("tick beat reported a target update");

    // A frame wrap restarts the counter
    a_wrap_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_op_reg == OP_TICK && wrap |=> tick_reg == 16'd0)
        else $error("frame wrap did not clear the counter");

    // Digit phase stays within the command length
    a_digit_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DIGITS |-> index_reg >= 4'd2 && index_reg < MAX_CHARS)
        else $error("digit position out of range");

    // The byte after a newline is dropped
    a_skip_drop: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_op_reg == OP_BYTE && phase_reg == PH_SKIP
        |=> !upd_out_reg && phase_reg == PH_IDLE)
        else $error("byte after newline was not discarded");
`endif

endmodule

@@ tb/servo_pwm_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the servo pulse generator: predicts line levels and target updates.
// Depends on spwm_pkg; watches the config, input and result channels of the block.
module servo_pwm_checker
    import spwm_pkg::*;
#(
    parameter int CHANNELS      = 4,
    parameter int CMD_MAX_CHARS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  servo_lines,
    input  logic        target_updated,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [3:0] lines;
        logic       updated;
    } servo_result_t;

    // Predicted block state
    logic [15:0] frame_len;
    logic [15:0] tick_cnt;
    pulse_t      target [CHANNELS];
    pulse_t      shadow [CHANNELS];
    logic [3:0]  levels;
    phase_t      parse_ph;
    logic [3:0]  char_idx;
    logic [7:0]  chan_char;
    logic [7:0]  value;
    logic        digits_done;

    servo_result_t expected_results [$];
    int errors = 0;
    int waiting = 0;

    assign fail_count = errors;
    assign pending    = waiting;

    // Write the commanded value into the addressed target; report whether it landed
    function automatic logic commit_target();
        if (chan_char <= CHAR_ZERO || chan_char > CHAR_ZERO + 8'(CHANNELS))
            return 1'b0;
        target[chan_char - CHAR_ZERO - 8'd1] = value;
        return 1'b1;
    endfunction

    // Advance the frame counter by one tick
    function automatic void frame_tick();
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= frame_len) begin
            tick_cnt = 16'd0;
            levels   = 4'hF;
            for (int n = 0; n < CHANNELS; n++)
                shadow[n] = target[n];
        end
        else begin
            for (int n = 0; n < CHANNELS; n++)
                if (tick_cnt == {8'd0, shadow[n]})
                    levels[n] = 1'b0;
        end
    endfunction

    // Feed one received byte through the command parser
    function automatic logic parse_byte(input logic [7:0] b);
        logic upd;
        logic counted;
        upd     = 1'b0;
        counted = 1'b1;
        case (parse_ph)
            PH_CHAN, PH_WANT_P, PH_DIGITS:
            begin
                if (b == CHAR_NEWLINE) begin
                    if (parse_ph != PH_CHAN)
                        upd = commit_target();
                    parse_ph = PH_SKIP;
                end
                else begin
                    if (parse_ph == PH_CHAN) begin
                        chan_char = b;
                        parse_ph  = PH_WANT_P;
                    end
                    else if (parse_ph == PH_WANT_P) begin
                        if (b != CHAR_P) begin
                            parse_ph = PH_IDLE;
                            counted  = 1'b0;
                        end
                        else begin
                            parse_ph = PH_DIGITS;
                        end
                    end
                    else begin
                        if (b == CHAR_NUL)
                            digits_done = 1'b1;
                        else if (!digits_done)
                            value = value * 8'd10 + b - CHAR_ZERO;
                    end
                    if (counted) begin
                        char_idx = char_idx + 4'd1;
                        if (char_idx >= CMD_MAX_CHARS) begin
                            upd      = commit_target();
                            parse_ph = PH_IDLE;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                parse_ph = PH_IDLE;
            end
            default:
            begin
                if (b == CHAR_S) begin
                    parse_ph    = PH_CHAN;
                    char_idx    = 4'd0;
                    chan_char   = 8'd0;
                    value       = 8'd0;
                    digits_done = 1'b0;
                end
                else begin
                    parse_ph = PH_IDLE;
                end
            end
        endcase
        return upd;
    endfunction

    // Compute the result beat that one input beat causes
    function automatic servo_result_t predict_result(input logic kind, input logic [7:0] b);
        servo_result_t res;
        res.updated = 1'b0;
        if (kind == OP_TICK)
            frame_tick();
        else
            res.updated = parse_byte(b);
        res.lines = levels;
        return res;
    endfunction

    // Track the channels: compare results first, then take config and input beats
    always @(posedge clk or negedge rst_n)
    begin
        servo_result_t exp_res;
        if (!rst_n) begin
            frame_len   = FRAME_DEFAULT;
            tick_cnt    = 16'd0;
            for (int n = 0; n < CHANNELS; n++) begin
                target[n] = (n < 4) ? TARGET_DEFAULT[n % 4] : 8'd0;
                shadow[n] = 8'd0;
            end
            levels      = 4'h0;
            parse_ph    = PH_IDLE;
            char_idx    = 4'd0;
            chan_char   = 8'd0;
            value       = 8'd0;
            digits_done = 1'b0;
            expected_results.delete();
            waiting     = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation: servo_lines %h, target_updated %b",
                           servo_lines, target_updated);
                    errors++;
                end
                else begin
                    exp_res = expected_results.pop_front();
                    if (servo_lines !== exp_res.lines) begin
                        $error("servo_lines mismatch: expected %h, actual %h",
                               exp_res.lines, servo_lines);
                        errors++;
                    end
                    if (target_updated !== exp_res.updated) begin
                        $error("target_updated mismatch: expected %b, actual %b",
                               exp_res.updated, target_updated);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                frame_len = cfg_data;
            if (in_valid && !in_stall)
                expected_results.push_back(predict_result(op, rx_byte));
            waiting = expected_results.size();
        end
    end

endmodule

@@ tb/tb_servo_pwm_with_serial_commands_top.sv @@
`timescale 1ns / 1ps
// Testbench top for servo_pwm_with_serial_commands_top: clock, reset, stimulus and verdict.
// Depends on spwm_pkg, the block itself and servo_pwm_checker for prediction and compare.
module tb_servo_pwm_with_serial_commands_top
    import spwm_pkg::*;
();

    localparam int ITEM_TARGET      = 1040;
    localparam int PHASE_ITEMS      = 200;
    localparam int SETTLE_TICKS     = 6;
    localparam int CMD_MAX_CHARS_TB = 10;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = 16'd0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        op        = OP_TICK;
    logic [7:0]  rx_byte   = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  servo_lines;
    logic        target_updated;
    int          fail_count;
    int          pending;

    int items_sent = 0;
    int burst_left = 0;

    servo_pwm_with_serial_commands_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .servo_lines    (servo_lines),
        .target_updated (target_updated)
    );

    servo_pwm_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .servo_lines    (servo_lines),
        .target_updated (target_updated),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Drive one input beat; open a new burst after a random gap when the last one ran out
    task automatic send_item(input logic kind, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        op       <= kind;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        burst_left--;
        items_sent++;
    endtask

    // Send a command byte, sometimes with a few ticks ahead of it
    task automatic put_byte(input logic [7:0] b);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_item(OP_TICK, 8'($urandom()));
        send_item(OP_BYTE, b);
    endtask

    // Hold off input until every result beat has come back, then let the pipe settle
    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write frame_length; call only while the block is idle
    task automatic set_frame(input logic [15:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random digit byte, mostly a decimal character
    function automatic logic [7:0] digit_byte();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0)
            return CHAR_NUL;
        if (r == 1)
            return 8'($urandom());
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // One command with random content; mostly well-formed, the rest broken in various ways
    task automatic send_command();
        int         form;
        int         r;
        logic [7:0] chan;
        logic [7:0] val;
        form = $urandom_range(0, 15);
        r    = $urandom_range(0, 15);
        if (r < 13)
            chan = CHAR_ZERO + 8'($urandom_range(1, 4));
        else if (r < 15)
            chan = 8'($urandom());
        else
            chan = CHAR_ZERO + 8'($urandom_range(0, 9));
        put_byte(CHAR_S);
        if (form == 0)
        begin
            // no channel given
            put_byte(CHAR_NEWLINE);
            put_byte(8'($urandom()));
            return;
        end
        put_byte(chan);
        if (form == 1)
        begin
            // newline right after the channel
            put_byte(CHAR_NEWLINE);
            put_byte(8'($urandom()));
            return;
        end
        if (form == 2)
        begin
            // wrong second byte
            do val = 8'($urandom()); while (val == CHAR_P || val == CHAR_NEWLINE);
            put_byte(val);
            return;
        end
        put_byte(CHAR_P);
        if (form <= 4)
        begin
            // run to the length limit without a newline
            repeat (CMD_MAX_CHARS_TB - 2) put_byte(digit_byte());
            return;
        end
        val = 8'($urandom_range(0, 255));
        if (form <= 6)
        begin
            repeat ($urandom_range(0, 4)) put_byte(digit_byte());
        end
        else
        begin
            if (val >= 100)
                put_byte(CHAR_ZERO + val / 100);
            if (val >= 10)
                put_byte(CHAR_ZERO + (val / 10) % 10);
            put_byte(CHAR_ZERO + val % 10);
        end
        put_byte(CHAR_NEWLINE);
        // this byte is swallowed after the newline
        put_byte(($urandom_range(0, 3) == 0) ? CHAR_S : 8'($urandom()));
    endtask

    // Receiver: stall on random patterns, each held for a random span
    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 5) != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int next_phase;
        int r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: parser corner cases at the reset frame length
        // letter A as a digit, then an 'S' that gets swallowed after the newline
        put_byte(CHAR_S); put_byte(CHAR_ZERO + 8'd1); put_byte(CHAR_P);
        put_byte(8'h41); put_byte(CHAR_NEWLINE); put_byte(CHAR_S);
        // newline right after the channel sets value zero
        put_byte(CHAR_S); put_byte(CHAR_ZERO + 8'd2); put_byte(CHAR_NEWLINE); put_byte(8'hFF);
        // newline with no channel
        put_byte(CHAR_S); put_byte(CHAR_NEWLINE); put_byte(CHAR_S);
        // wrong second byte
        put_byte(CHAR_S); put_byte(CHAR_ZERO + 8'd3); put_byte(8'h51);
        // zero byte ends the digits
        put_byte(CHAR_S); put_byte(CHAR_ZERO + 8'd4); put_byte(CHAR_P);
        put_byte(CHAR_ZERO + 8'd2); put_byte(CHAR_NUL); put_byte(CHAR_ZERO + 8'd7);
        put_byte(CHAR_NEWLINE); put_byte(8'h80);
        // 'S' as the channel character is invalid
        put_byte(CHAR_S); put_byte(CHAR_S); put_byte(CHAR_NEWLINE); put_byte(8'h00);

        // Directed: frame length extremes
        drain_results();
        set_frame(16'd0);
        send_item(OP_TICK, 8'h00); send_item(OP_TICK, 8'hFF);
        drain_results();
        set_frame(16'd1);
        send_item(OP_TICK, 8'hAA); send_item(OP_TICK, 8'h55);
        drain_results();
        set_frame(16'hFFFF);
        send_item(OP_TICK, 8'h0F);

        // Random phases, each with its own frame length
        next_phase = items_sent;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_phase)
            begin
                drain_results();
                r = $urandom_range(0, 9);
                if (r == 0)
                    set_frame(16'd1);
                else if (r == 1)
                    set_frame(16'($urandom_range(2, 20)));
                else
                    set_frame(16'($urandom_range(20, 300)));
                next_phase += PHASE_ITEMS;
            end
            r = $urandom_range(0, 9);
            if (r < 4)
                send_command();
            else if (r < 7)
                repeat ($urandom_range(1, 30)) send_item(OP_TICK, 8'($urandom()));
            else if (r < 9)
                send_item(OP_BYTE, 8'($urandom()));
            else
                send_item(OP_TICK, 8'($urandom()));
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb_servo_pwm_with_serial_commands_top passed");
        else
            $display("tb_servo_pwm_with_serial_commands_top failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("tb_servo_pwm_with_serial_commands_top failed");
        $finish;
    end

endmodule
